// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define FXDT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// checked at every clock edge, reset included
`define FXDT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

// File: design/fxdt_pkg.sv
`timescale 1ns / 1ps

package fxdt_pkg;

    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int PLACES_W = 4;
    localparam int POW10_W  = 30;

    localparam logic [PLACES_W-1:0] PLACES_RESET = 4'd2;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [POW10_W-1:0] POW10 [0:9] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef struct packed {
        logic load;
        logic shift;
    } dab_ctrl_t;

endpackage

// File: design/fixed_to_decimal_text.sv
`timescale 1ns / 1ps

// Prints a signed fixed-point number (FRAC_BITS fraction bits, 64 bits wide) as ASCII
// text, one character per output beat, tlast on the final one: an optional '-', the
// integer digits without leading zeros, then, unless decimal_places is zero, '.' and
// decimal_places fraction digits (0 to MAX_DEC_PLACES, larger register values
// saturate), rounded half-up exactly. A negative value that rounds to zero still
// prints its '-'. One number is handled at a time: a bit-serial multiply of the
// fraction by 10^places, a rounding step, a shift-add-3 binary to BCD conversion, a
// step to latch the digits, then an alignment in which integer leading zeros and the
// unused top fraction digits are dropped side by side (at most the larger of one less
// than the integer digit count and MAX_DEC_PLACES), then one character per cycle
// while m_tready is high. With default parameters a number prints as up to 21
// characters. s_tready is high only between numbers; the last character may still
// wait in the output register while the next number is taken. decimal_places
// may be written at any time the block is idle; its reset value is 2.
module fixed_to_decimal_text #(
    parameter int FRAC_BITS      = 32,
    parameter int MAX_DEC_PLACES = 9
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // value
    input  logic signed [fxdt_pkg::VALUE_W-1:0]  s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // char_code
    output logic [fxdt_pkg::CHAR_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [fxdt_pkg::PLACES_W-1:0]        cfg_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);

    localparam int IW    = fxdt_pkg::VALUE_W - FRAC_BITS;
    localparam int ND    = (IW * 30103) / 100000 + 1;
    localparam int QW    = (MAX_DEC_PLACES * 33220) / 10000 + 1;
    localparam int M     = MAX_DEC_PLACES;
    localparam int DABN  = (IW > QW) ? IW : QW;
    localparam int CMAX  = (DABN > FRAC_BITS) ? DABN : FRAC_BITS;
    localparam int CW    = $clog2(CMAX + 1);
    localparam int ICW   = $clog2(ND + 1);
    localparam int FCW   = $clog2(M + 1);
    localparam int PW    = fxdt_pkg::PLACES_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ROUND, S_DAB, S_ALIGN, S_SKIP,
        S_SIGN, S_INT, S_POINT, S_FRAC
    } state_t;

    state_t state_reg, state_next;

    logic [PW-1:0]          places_cfg_reg, places_cfg_next;
    logic [PW-1:0]          places_reg, places_next;
    logic                   neg_reg, neg_next;
    logic [IW-1:0]          ipart_reg, ipart_next;
    logic [QW-1:0]          hi_reg, hi_next;
    logic [FRAC_BITS-1:0]   lo_reg, lo_next;
    logic [QW-1:0]          scale_reg, scale_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [ND*4-1:0]        int_dig_reg, int_dig_next;
    logic [M*4-1:0]         frac_dig_reg, frac_dig_next;
    logic [ICW-1:0]         icnt_reg, icnt_next;
    logic [FCW-1:0]         fskip_reg, fskip_next;
    logic [FCW-1:0]         fcnt_reg, fcnt_next;
    logic [fxdt_pkg::CHAR_W-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_valid_reg, m_valid_next;

    logic [fxdt_pkg::VALUE_W-1:0] mag;
    logic [PW-1:0]          places_sat;
    logic [fxdt_pkg::POW10_W-1:0] pow_sel;
    logic [QW:0]            mul_sum;
    logic [QW:0]            q_sum;
    logic [QW:0]            q_sub;
    logic                   round_up;
    logic [IW-1:0]          int_bin;
    logic [QW-1:0]          frac_bin;
    logic                   out_free;
    logic                   int_skip;
    logic [3:0]             int_top;
    logic [3:0]             frac_top;

    fxdt_pkg::dab_ctrl_t    int_ctrl, frac_ctrl;
    logic [ND*4-1:0]        int_bcd;
    logic [M*4-1:0]         frac_bcd;

    fxdt_dabble #(.BIN_W(IW), .DIGITS(ND)) u_int_dabble (
        .aclk   (aclk),
        .ctrl   (int_ctrl),
        .bin_in (int_bin),
        .bcd    (int_bcd)
    );

    fxdt_dabble #(.BIN_W(QW), .DIGITS(M)) u_frac_dabble (
        .aclk   (aclk),
        .ctrl   (frac_ctrl),
        .bin_in (frac_bin),
        .bcd    (frac_bcd)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign m_tvalid  = m_valid_reg;

    assign mag        = s_tdata[fxdt_pkg::VALUE_W-1] ? -s_tdata : s_tdata;
    assign places_sat = (places_cfg_reg > PW'(M)) ? PW'(M) : places_cfg_reg;
    assign pow_sel    = fxdt_pkg::POW10[places_sat];

    // one partial product per cycle, fraction bits consumed from the bottom
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, scale_reg} : '0);

    // adding half a unit rounds up exactly when the top low bit is set
    assign q_sum    = {1'b0, hi_reg} + (QW+1)'(lo_reg[FRAC_BITS-1]);
    assign round_up = (q_sum >= {1'b0, scale_reg});
    assign q_sub    = q_sum - {1'b0, scale_reg};
    assign frac_bin = round_up ? q_sub[QW-1:0] : q_sum[QW-1:0];
    assign int_bin  = ipart_reg + IW'(round_up);

    assign int_ctrl.load   = (state_reg == S_ROUND);
    assign int_ctrl.shift  = (state_reg == S_DAB) && (cnt_reg < CW'(IW));
    assign frac_ctrl.load  = (state_reg == S_ROUND);
    assign frac_ctrl.shift = (state_reg == S_DAB) && (cnt_reg < CW'(QW));

    assign out_free = !m_valid_reg || m_tready;
    assign int_top  = int_dig_reg[ND*4-1 -: 4];
    assign frac_top = frac_dig_reg[M*4-1 -: 4];
    assign int_skip = (int_top == 4'd0) && (icnt_reg > ICW'(1));

    always_comb begin
        state_next      = state_reg;
        places_cfg_next = places_cfg_reg;
        places_next     = places_reg;
        neg_next        = neg_reg;
        ipart_next      = ipart_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        scale_next      = scale_reg;
        cnt_next        = cnt_reg;
        int_dig_next    = int_dig_reg;
        frac_dig_next   = frac_dig_reg;
        icnt_next       = icnt_reg;
        fskip_next      = fskip_reg;
        fcnt_next       = fcnt_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        if (cfg_valid) begin
            places_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    neg_next    = s_tdata[fxdt_pkg::VALUE_W-1];
                    ipart_next  = mag[fxdt_pkg::VALUE_W-1:FRAC_BITS];
                    lo_next     = mag[FRAC_BITS-1:0];
                    hi_next     = '0;
                    cnt_next    = '0;
                    places_next = places_sat;
                    scale_next  = pow_sel[QW-1:0];
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                hi_next  = mul_sum[QW:1];
                lo_next  = {mul_sum[0], lo_reg[FRAC_BITS-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS - 1)) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cnt_next   = '0;
                state_next = S_DAB;
            end
            S_DAB: begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DABN - 1)) begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN: begin
                int_dig_next  = int_bcd;
                frac_dig_next = frac_bcd;
                icnt_next     = ICW'(ND);
                fskip_next    = FCW'(PW'(M) - places_reg);
                fcnt_next     = FCW'(places_reg);
                state_next    = S_SKIP;
            end
            S_SKIP: begin
                // drop leading zeros and the unused top fraction digits
                if (int_skip) begin
                    int_dig_next = int_dig_reg << 4;
                    icnt_next    = icnt_reg - ICW'(1);
                end
                if (fskip_reg != '0) begin
                    frac_dig_next = frac_dig_reg << 4;
                    fskip_next    = fskip_reg - FCW'(1);
                end
                if (!int_skip && (fskip_reg == '0)) begin
                    state_next = neg_reg ? S_SIGN : S_INT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_data_next  = fxdt_pkg::CH_MINUS;
                    m_last_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = S_INT;
                end
            end
            S_INT: begin
                if (out_free) begin
                    m_data_next  = fxdt_pkg::CH_ZERO + {4'd0, int_top};
                    m_valid_next = 1'b1;
                    int_dig_next = int_dig_reg << 4;
                    icnt_next    = icnt_reg - ICW'(1);
                    m_last_next  = 1'b0;
                    if (icnt_reg == ICW'(1)) begin
                        if (places_reg != '0) begin
                            state_next = S_POINT;
                        end else begin
                            m_last_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end
            S_POINT: begin
                if (out_free) begin
                    m_data_next  = fxdt_pkg::CH_POINT;
                    m_last_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_free) begin
                    m_data_next   = fxdt_pkg::CH_ZERO + {4'd0, frac_top};
                    m_valid_next  = 1'b1;
                    frac_dig_next = frac_dig_reg << 4;
                    fcnt_next     = fcnt_reg - FCW'(1);
                    m_last_next   = (fcnt_reg == FCW'(1));
                    if (fcnt_reg == FCW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            places_cfg_reg <= fxdt_pkg::PLACES_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            places_cfg_reg <= places_cfg_next;
            m_valid_reg    <= m_valid_next;
        end
        places_reg   <= places_next;
        neg_reg      <= neg_next;
        ipart_reg    <= ipart_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        scale_reg    <= scale_next;
        cnt_reg      <= cnt_next;
        int_dig_reg  <= int_dig_next;
        frac_dig_reg <= frac_dig_next;
        icnt_reg     <= icnt_next;
        fskip_reg    <= fskip_next;
        fcnt_reg     <= fcnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule

// File: design/fxdt_dabble.sv
`timescale 1ns / 1ps

module fxdt_dabble #(
    parameter int BIN_W  = 32,
    parameter int DIGITS = 10
) (
    input  logic                  aclk,
    input  fxdt_pkg::dab_ctrl_t   ctrl,
    input  logic [BIN_W-1:0]      bin_in,
    output logic [DIGITS*4-1:0]   bcd
);

    logic [BIN_W-1:0]    bin_reg;
    logic [BIN_W-1:0]    bin_next;
    logic [DIGITS*4-1:0] bcd_reg;
    logic [DIGITS*4-1:0] bcd_next;
    logic [DIGITS*4-1:0] bcd_adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < DIGITS; i++) begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load) begin
            bin_next = bin_in;
            bcd_next = '0;
        end else if (ctrl.shift) begin
            bin_next = bin_reg << 1;
            bcd_next = {bcd_adj[DIGITS*4-2:0], bin_reg[BIN_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

// File: design/fxdt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fxdt_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [fxdt_pkg::CHAR_W-1:0]          m_tdata,
    input  logic                                 m_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready
);

    // a stalled result holds
    `FXDT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // one number at a time: busy right after a request is taken
    `FXDT_ASSERT(a_busy_after_req, s_tvalid && s_tready |=> !s_tready)

    // the text always ends on a digit
    `FXDT_ASSERT(a_last_digit, m_tvalid && m_tlast |-> m_tdata[7:4] == 4'h3 && m_tdata[3:0] <= 4'h9)

    // nothing comes out of reset
    `FXDT_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid)

endmodule

bind fixed_to_decimal_text fxdt_checker u_fxdt_checker (.*);
